// File: sv/assert_macros.svh
// Assertion macros shared by the RTL that checks its own control flow.
// Needs clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPS_ASSERT_IMP(lbl, ante, cons, msg)
`define TPS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/tps_pkg.sv
// Shared types, codes, defaults and the log table of the spline evaluator.
// No dependencies.
`default_nettype none
package tps_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int MAX_DIMS_DEF  = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NCOL          = 4;
  localparam int LN2_Q16       = 45426;
  localparam int DRAIN_CYCLES  = 24;

  localparam logic [1:0] CMD_LOAD_KNOT = 2'd0;
  localparam logic [1:0] CMD_LOAD_AFF  = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [1:0] CFG_ACTIVE_KNOTS = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_DIMS  = 2'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         slot;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] a3;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] b3;
    logic               last_in;
  } tps_in_t;

  typedef struct packed {
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] y3;
    logic               last_out;
    logic               not_ready;
  } tps_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } tps_cfg_t;

  typedef struct packed {
    logic               vld;
    logic               aff;
    logic signed [31:0] x;
  } tps_item_t;

  typedef struct packed {
    logic acc_clr;
    logic warp_we;
    logic aff_we;
  } tps_cell_ctl_t;

  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/tps_stream_if.sv
// Valid/ready channel carrying one payload struct.
// Payload type is set per instance from tps_pkg types.
`default_nettype none
interface tps_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/tps_kernel.sv
// Knot store and pipelined radial kernel: squared distance, log, 0.5*r2*ln(r2).
// Depends on tps_pkg.
`default_nettype none
module tps_kernel import tps_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_KNOTS)-1:0] wr_slot,
  input  logic [NCOL-1:0][31:0]        wr_vec,
  input  logic [NCOL-1:0][31:0]        qry,
  input  logic [1:0]                   dims,
  input  logic                         issue,
  input  logic [$clog2(MAX_KNOTS)-1:0] issue_k,
  output logic                         u_vld,
  output logic signed [31:0]           u,
  output logic [$clog2(MAX_KNOTS)-1:0] u_k
);
  localparam int KW     = $clog2(MAX_KNOTS);
  localparam int SQW    = 64 - FRAC_BITS;
  localparam int RW     = SQW + 2;
  localparam int NCH    = (RW + 15) / 16;
  localparam int HW     = RW - 32;
  localparam int THRESH = (1 << FRAC_BITS) / 100000;
  localparam int NST    = 11;

  logic [MAX_DIMS-1:0][31:0] knot_mem [MAX_KNOTS];
  logic [MAX_DIMS-1:0][31:0] wd, kd, mq, mc;
  logic [MAX_DIMS-1:0][SQW-1:0] sqq;
  logic                 vs  [NST];
  logic [KW-1:0]        ks  [NST];
  logic [RW-1:0]        rr  [NST];
  logic                 kz  [NST];
  logic [RW-1:0]        rsum;
  logic [NCH*16-1:0]    rp;
  logic [1:0]           hc, hcq;
  logic [15:0]          cv, cvq;
  logic [3:0]           pos;
  logic [5:0]           pq, pq6;
  logic [RW+19:0]       rs;
  logic [19:0]          fq;
  logic [15:0]          lo, hi, loq;
  logic [31:0]          prodq;
  logic signed [7:0]    pe;
  logic signed [25:0]   baseq, ln;
  logic                 negq, neg9;
  logic [24:0]          magq;
  logic [HW+24:0]       rh;
  logic [56:0]          rl;
  logic [40:0]          mg;
  logic signed [31:0]   uc;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      logic signed [32:0] e;
      wd[i] = wr_vec[i];
      e = {qry[i][31], qry[i]} - {kd[i][31], kd[i]};
      mc[i] = e[32] ? 32'(-e) : e[31:0];
      if (32'(i) >= 32'(dims)) mc[i] = '0;
    end
  end

  always_comb begin
    rsum = '0;
    for (int i = 0; i < MAX_DIMS; i++) rsum = rsum + RW'(sqq[i]);
  end

  always_comb begin
    rp = (NCH*16)'(rr[3]);
    hc = '0;
    for (int c = 0; c < NCH; c++) if (|rp[c*16 +: 16]) hc = 2'(c);
    cv = rp[hc*16 +: 16];
    pos = '0;
    for (int b = 0; b < 16; b++) if (cvq[b]) pos = 4'(b);
    rs = {rr[5], 20'b0} >> pq;
    lo = ln_tab({1'b0, fq[19:16]});
    hi = ln_tab(5'({1'b0, fq[19:16]}) + 5'd1);
    pe = $signed({2'b0, pq6}) - 8'(FRAC_BITS);
    ln = baseq + $signed({10'b0, loq}) + $signed({10'b0, prodq[31:16]});
    if (rh >= (HW+25)'(65536)) mg = 41'(64'h8000_0000);
    else mg = (41'(rh[15:0]) << 15) + 41'(rl >> 17);
    if (mg > 41'(64'h8000_0000)) mg = 41'(64'h8000_0000);
    if (kz[9]) uc = '0;
    else if (neg9) uc = 32'(-mg);
    else if (mg > 41'(32'h7FFF_FFFF)) uc = 32'h7FFF_FFFF;
    else uc = mg[31:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) knot_mem[wr_slot] <= wd;
    kd <= knot_mem[issue_k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) vs[s] <= 1'b0;
    end else begin
      vs[0] <= issue;
      for (int s = 1; s < NST; s++) vs[s] <= vs[s-1];
    end
  end

  always_ff @(posedge clk) begin
    ks[0] <= issue_k;
    for (int s = 1; s < NST; s++) ks[s] <= ks[s-1];
    rr[0] <= '0;
    kz[0] <= 1'b0;
    for (int s = 1; s < NST; s++) begin
      if (s != 3) begin
        rr[s] <= rr[s-1];
        kz[s] <= kz[s-1];
      end
    end
    mq <= mc;
    for (int i = 0; i < MAX_DIMS; i++)
      sqq[i] <= SQW'((64'(mq[i]) * 64'(mq[i])) >> FRAC_BITS);
    rr[3] <= rsum;
    kz[3] <= rsum <= RW'(THRESH);
    hcq   <= hc;
    cvq   <= cv;
    pq    <= {hcq, pos};
    fq    <= rs[19:0];
    pq6   <= pq;
    prodq <= 32'(hi - lo) * 32'(fq[15:0]);
    loq   <= lo;
    baseq <= 26'(pe) * 26'(LN2_Q16);
    negq  <= ln < 0;
    magq  <= (ln < 0) ? 25'(-ln) : ln[24:0];
    neg9  <= negq;
    rh    <= (HW+25)'(rr[8][RW-1:32]) * (HW+25)'(magq);
    rl    <= 57'(rr[8][31:0]) * 57'(magq);
    u     <= uc;
  end

  assign u_vld = vs[10];
  assign u_k   = ks[10];

endmodule
`default_nettype wire

// File: sv/tps_cell.sv
// One output-column cell: warp column memory, affine column, MAC and accumulator.
// Depends on tps_pkg; cells are chained and pass each request to the next.
`default_nettype none
module tps_cell import tps_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tps_cell_ctl_t                ctl,
  input  logic [$clog2(MAX_KNOTS)-1:0] wr_slot,
  input  logic [1:0]                   aff_row,
  input  logic [31:0]                  warp_data,
  input  logic [31:0]                  aff_data,
  input  tps_item_t                    item_in,
  input  logic [$clog2(MAX_KNOTS)-1:0] idx_in,
  output tps_item_t                    item_out,
  output logic [$clog2(MAX_KNOTS)-1:0] idx_out,
  output logic signed [63:0]           acc
);
  logic [31:0]        warp_mem [MAX_KNOTS];
  logic [31:0]        aff [NCOL];
  logic signed [31:0] w_q, a_q, coef;
  tps_item_t          it_q;
  logic               v2;
  logic signed [63:0] prod;

  assign coef = it_q.aff ? a_q : w_q;

  always_ff @(posedge clk) begin
    if (ctl.warp_we) warp_mem[wr_slot] <= warp_data;
    w_q <= warp_mem[idx_in];
  end

  always_ff @(posedge clk) begin
    if (ctl.aff_we) aff[aff_row] <= aff_data;
    a_q <= aff[idx_in[1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it_q <= '0;
      v2   <= 1'b0;
      acc  <= '0;
    end else begin
      it_q <= item_in;
      v2   <= it_q.vld;
      if (ctl.acc_clr) acc <= '0;
      else if (v2) acc <= acc + (prod >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    idx_out <= idx_in;
    prod    <= 64'(it_q.x) * 64'(coef);
  end

  assign item_out = it_q;

endmodule
`default_nettype wire

// File: sv/thin_plate_spline_evaluator.sv
// Thin-plate spline evaluator top: command decode, query sequencer, kernel and cell chain.
// Depends on tps_pkg, tps_stream_if, tps_kernel, tps_cell and assert_macros.svh.
//
//  channel   dir  payload    accepted when
//  cfg_ch    in   tps_cfg_t  valid && ready (ready always high)
//  in_ch     in   tps_in_t   valid && ready (ready in idle only)
//  out_ch    out  tps_out_t  valid && ready
//
// Loads are written when accepted. A query steps through its four affine terms, then issues
// one active knot per cycle into the kernel pipeline, then drains the kernel and cell chain;
// a query before any knot load goes straight to the result with not_ready set.
// Reset is synchronous; knot, warp and affine stores are not cleared.
// A stalled result is held in the output register while the next request is taken.
`default_nettype none
`include "assert_macros.svh"
module thin_plate_spline_evaluator import tps_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tps_stream_if.sink   cfg_ch,
  tps_stream_if.sink   in_ch,
  tps_stream_if.source out_ch
);
  localparam int KW  = $clog2(MAX_KNOTS);
  localparam int NKW = $clog2(MAX_KNOTS + 1);
  localparam int DCW = $clog2(DRAIN_CYCLES + 1);

  typedef enum logic [2:0] {S_IDLE, S_AFF, S_KNOT, S_DRAIN, S_FIN} state_t;

  state_t              state;
  logic [NKW-1:0]      cnt, nk;
  logic [DCW-1:0]      dcnt;
  logic [6:0]          active_knots;
  logic [1:0]          active_dims, dims_c, dims_q;
  logic                knots_ready;
  logic [NCOL-1:0][31:0] q, a_vec, b_vec, y;
  logic [NCOL-1:0]     on_c, on_q;
  logic                last_q, nrdy_q, out_vld, last_o, nrdy_o;
  logic                in_acc, ld_knot, ld_aff, is_query;
  tps_cell_ctl_t       ctl;
  logic [KW-1:0]       wr_slot;
  logic                u_vld;
  logic signed [31:0]  u;
  logic [KW-1:0]       u_k;
  tps_item_t           item [NCOL+1];
  logic [KW-1:0]       idx  [NCOL+1];
  logic signed [63:0]  acc  [NCOL];

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign ld_knot  = in_acc && in_ch.payload.cmd == CMD_LOAD_KNOT &&
                    32'(in_ch.payload.slot) < MAX_KNOTS;
  assign ld_aff   = in_acc && in_ch.payload.cmd == CMD_LOAD_AFF &&
                    32'(in_ch.payload.slot) < NCOL;
  assign is_query = in_acc && in_ch.payload.cmd == CMD_QUERY;
  assign wr_slot  = KW'(in_ch.payload.slot);
  assign a_vec = {in_ch.payload.a3, in_ch.payload.a2, in_ch.payload.a1, in_ch.payload.a0};
  assign b_vec = {in_ch.payload.b3, in_ch.payload.b2, in_ch.payload.b1, in_ch.payload.b0};

  assign ctl.acc_clr = is_query;
  assign ctl.warp_we = ld_knot;
  assign ctl.aff_we  = ld_aff;

  always_comb begin
    nk = (32'(active_knots) > MAX_KNOTS) ? NKW'(MAX_KNOTS) : NKW'(active_knots);
    dims_c = (32'(active_dims) > MAX_DIMS) ? 2'(MAX_DIMS) : active_dims;
    for (int i = 0; i < NCOL; i++) on_c[i] = (i == NCOL - 1) || (32'(i) < 32'(dims_c));
  end

  assign in_ch.ready  = state == S_IDLE;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      knots_ready  <= 1'b0;
      active_knots <= 7'd64;
      active_dims  <= 2'd2;
      out_vld      <= 1'b0;
      cnt          <= '0;
      dcnt         <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.payload.index)
          CFG_ACTIVE_KNOTS: active_knots <= cfg_ch.payload.data[6:0];
          CFG_ACTIVE_DIMS:  active_dims  <= cfg_ch.payload.data[1:0];
          default: ;
        endcase
      end
      if (out_ch.ready && state != S_FIN) out_vld <= 1'b0;
      if (ld_knot) knots_ready <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (is_query) begin
            q      <= a_vec;
            on_q   <= on_c;
            dims_q <= dims_c;
            last_q <= in_ch.payload.last_in;
            nrdy_q <= !knots_ready;
            cnt    <= '0;
            state  <= knots_ready ? S_AFF : S_FIN;
          end
        end
        S_AFF: begin
          if (cnt[1:0] == 2'd3) begin
            cnt   <= '0;
            dcnt  <= '0;
            state <= (nk == '0) ? S_DRAIN : S_KNOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_KNOT: begin
          if (NKW'(cnt + 1'b1) == nk) begin
            dcnt  <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (dcnt == DCW'(DRAIN_CYCLES - 1)) state <= S_FIN;
          else dcnt <= dcnt + 1'b1;
        end
        S_FIN: begin
          if (!out_vld || out_ch.ready) begin
            out_vld <= 1'b1;
            for (int j = 0; j < NCOL; j++) y[j] <= on_q[j] ? sat32(acc[j]) : 32'd0;
            last_o  <= last_q;
            nrdy_o  <= nrdy_q;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tps_kernel #(
    .MAX_KNOTS(MAX_KNOTS), .MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS)
  ) u_kernel (
    .clk, .rst,
    .wr_en(ld_knot), .wr_slot, .wr_vec(a_vec),
    .qry(q), .dims(dims_q),
    .issue(state == S_KNOT), .issue_k(cnt[KW-1:0]),
    .u_vld, .u, .u_k
  );

  always_comb begin
    if (state == S_AFF) begin
      item[0].vld = on_q[cnt[1:0]];
      item[0].aff = 1'b1;
      item[0].x   = q[cnt[1:0]];
      idx[0]      = KW'(cnt[1:0]);
    end else begin
      item[0].vld = u_vld;
      item[0].aff = 1'b0;
      item[0].x   = u;
      idx[0]      = u_k;
    end
  end

  for (genvar j = 0; j < NCOL; j++) begin : g_cell
    tps_cell #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk, .rst, .ctl, .wr_slot,
      .aff_row(in_ch.payload.slot[1:0]),
      .warp_data(b_vec[j]), .aff_data(a_vec[j]),
      .item_in(item[j]), .idx_in(idx[j]),
      .item_out(item[j+1]), .idx_out(idx[j+1]),
      .acc(acc[j])
    );
  end

  assign out_ch.valid             = out_vld;
  assign out_ch.payload.y0        = y[0];
  assign out_ch.payload.y1        = y[1];
  assign out_ch.payload.y2        = y[2];
  assign out_ch.payload.y3        = y[3];
  assign out_ch.payload.last_out  = last_o;
  assign out_ch.payload.not_ready = nrdy_o;

  `TPS_ASSERT_IMP(a_no_collide, state == S_AFF, !u_vld, "kernel result during affine phase")
  `TPS_ASSERT_NXT(a_unready_fast, is_query && !knots_ready, state == S_FIN, "unready query not short-cut")
  `TPS_ASSERT_IMP(a_unready_zero, out_vld && nrdy_o, y == '0, "unready result not zero")

endmodule
`default_nettype wire

// File: dv/tb_thin_plate_spline_evaluator.sv
// Testbench for thin_plate_spline_evaluator: directed and random loads and queries,
// register phases and random backpressure, results checked against an in-bench predictor.
// Depends on tps_pkg, tps_stream_if and the evaluator RTL.
`default_nettype none
module tb_thin_plate_spline_evaluator;
  import tps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 5 * DRAIN_CYCLES;

  localparam longint LN_STEP[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
    26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

  logic clk;
  logic rst;

  tps_stream_if #(.payload_t(tps_cfg_t)) cfg_ch();
  tps_stream_if #(.payload_t(tps_in_t))  in_ch();
  tps_stream_if #(.payload_t(tps_out_t)) out_ch();

  thin_plate_spline_evaluator u_dut (
    .clk(clk), .rst(rst), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  logic signed [31:0] knot_mem [MAX_KNOTS_DEF][MAX_DIMS_DEF];
  logic signed [31:0] warp_mem [MAX_KNOTS_DEF][NCOL];
  logic signed [31:0] aff_mem  [NCOL][NCOL];
  logic               knots_loaded;
  logic [6:0]         knots_reg;
  logic [1:0]         dims_reg;

  tps_in_t  pending_requests [$];
  tps_out_t expected_warps [$];
  int       fail_count;
  int       in_taken;
  int       gap_cnt;
  int       gap_max;
  int       stall_cnt;
  int       stall_max;
  int       hold_left;
  bit       hold_done;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint ln_fixed(longint unsigned r);
    int p;
    longint unsigned f;
    longint lo, hi;
    p = 63;
    while (p > 0 && r[p] == 1'b0) p--;
    if (p >= 20) f = (r >> (p - 20)) & 64'hFFFFF;
    else f = (r << (20 - p)) & 64'hFFFFF;
    lo = LN_STEP[f >> 16];
    hi = LN_STEP[(f >> 16) + 1];
    return longint'(p - FRAC_BITS_DEF) * LN2_Q16 + lo
         + longint'((unsigned'(hi - lo) * (f & 64'hFFFF)) >> 16);
  endfunction

  function automatic longint radial_kernel(longint unsigned r);
    longint ln;
    longint unsigned mag, hi;
    bit neg;
    if (r <= ((64'd1 << FRAC_BITS_DEF) / 100000)) return 0;
    ln = ln_fixed(r);
    neg = ln < 0;
    mag = neg ? unsigned'(-ln) : unsigned'(ln);
    hi = (r >> 32) * mag;
    if (hi >= (64'd1 << 16)) mag = 64'd1 << 31;
    else mag = (hi << 15) + (((r & 64'hFFFFFFFF) * mag) >> 17);
    if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
    if (neg) return -longint'(mag);
    return mag > 64'h7FFFFFFF ? 64'h7FFFFFFF : longint'(mag);
  endfunction

  function automatic logic [31:0] sat_word(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic apply_request(input tps_in_t it);
    longint av[NCOL], bv[NCOL], acc[NCOL];
    bit on[NCOL];
    int dims, nk;
    longint e, u;
    longint unsigned m, r;
    tps_out_t res;
    av = '{longint'(it.a0), longint'(it.a1), longint'(it.a2), longint'(it.a3)};
    bv = '{longint'(it.b0), longint'(it.b1), longint'(it.b2), longint'(it.b3)};
    case (it.cmd)
      CMD_LOAD_KNOT: begin
        for (int i = 0; i < MAX_DIMS_DEF; i++) knot_mem[it.slot][i] = av[i][31:0];
        for (int j = 0; j < NCOL; j++) warp_mem[it.slot][j] = bv[j][31:0];
        knots_loaded = 1'b1;
      end
      CMD_LOAD_AFF: begin
        if (it.slot < NCOL)
          for (int j = 0; j < NCOL; j++) aff_mem[it.slot][j] = av[j][31:0];
      end
      CMD_QUERY: begin
        dims = (dims_reg > MAX_DIMS_DEF) ? MAX_DIMS_DEF : dims_reg;
        nk = (knots_reg > MAX_KNOTS_DEF) ? MAX_KNOTS_DEF : knots_reg;
        for (int i = 0; i < NCOL; i++) begin
          on[i] = (i == NCOL - 1) || (i < dims);
          acc[i] = 0;
        end
        if (knots_loaded) begin
          for (int j = 0; j < NCOL; j++)
            if (on[j])
              for (int i = 0; i < NCOL; i++)
                if (on[i]) acc[j] += (av[i] * longint'(aff_mem[i][j])) >>> FRAC_BITS_DEF;
          for (int k = 0; k < nk; k++) begin
            r = 0;
            for (int i = 0; i < dims; i++) begin
              e = av[i] - longint'(knot_mem[k][i]);
              m = e < 0 ? unsigned'(-e) : unsigned'(e);
              r += (m * m) >> FRAC_BITS_DEF;
            end
            u = radial_kernel(r);
            for (int j = 0; j < NCOL; j++)
              if (on[j]) acc[j] += (u * longint'(warp_mem[k][j])) >>> FRAC_BITS_DEF;
          end
        end
        res.y0 = on[0] ? sat_word(acc[0]) : '0;
        res.y1 = on[1] ? sat_word(acc[1]) : '0;
        res.y2 = on[2] ? sat_word(acc[2]) : '0;
        res.y3 = sat_word(acc[3]);
        res.last_out = it.last_in;
        res.not_ready = !knots_loaded;
        expected_warps.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.payload);
        in_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_ch.payload <= pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          gap_cnt <= $urandom_range(0, gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tps_out_t want;
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_warps.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        fail_count++;
      end else begin
        want = expected_warps.pop_front();
        if (out_ch.payload.y0 !== want.y0) report_mismatch("y0", out_ch.payload.y0, want.y0);
        if (out_ch.payload.y1 !== want.y1) report_mismatch("y1", out_ch.payload.y1, want.y1);
        if (out_ch.payload.y2 !== want.y2) report_mismatch("y2", out_ch.payload.y2, want.y2);
        if (out_ch.payload.y3 !== want.y3) report_mismatch("y3", out_ch.payload.y3, want.y3);
        if (out_ch.payload.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_ch.payload.last_out), 32'(want.last_out));
        if (out_ch.payload.not_ready !== want.not_ready)
          report_mismatch("not_ready", 32'(out_ch.payload.not_ready), 32'(want.not_ready));
      end
      n = $urandom_range(0, stall_max);
      stall_cnt <= n;
      out_ch.ready <= (n == 0) && (hold_left == 0);
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= (stall_cnt == 1) && (hold_left == 0);
    end else begin
      out_ch.ready <= (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && in_taken >= 300) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("thin_plate_spline_evaluator verification failed");
        $finish;
      end
    end
  end

  function automatic tps_in_t make_request(logic [1:0] cmd, logic [5:0] slot,
      logic [31:0] a0, logic [31:0] a1, logic [31:0] a2, logic [31:0] a3, logic last);
    tps_in_t it;
    it.cmd = cmd;
    it.slot = slot;
    it.a0 = a0;
    it.a1 = a1;
    it.a2 = a2;
    it.a3 = a3;
    it.b0 = $urandom();
    it.b1 = $urandom();
    it.b2 = $urandom();
    it.b3 = $urandom();
    it.last_in = last;
    return it;
  endfunction

  function automatic logic [31:0] pick_coord(int dim);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: v = knot_mem[$urandom_range(0, MAX_KNOTS_DEF - 1)][dim]
             + 32'($signed($urandom_range(0, 2048)) - 1024);
      3: v = knot_mem[$urandom_range(0, MAX_KNOTS_DEF - 1)][dim]
             + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: v = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
    endcase
  endfunction

  task automatic push_random(int count);
    int sel;
    tps_in_t it;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        it = make_request(CMD_QUERY, 6'($urandom()), pick_coord(0), pick_coord(1),
                          pick_coord(2),
                          $urandom_range(0, 3) == 0 ? pick_scale() : 32'h00010000,
                          1'($urandom_range(0, 1)));
      end else if (sel < 80) begin
        it = make_request(CMD_LOAD_KNOT, 6'($urandom_range(0, MAX_KNOTS_DEF - 1)),
                          pick_coord(0), pick_coord(1), pick_coord(2), $urandom(),
                          1'($urandom_range(0, 1)));
        it.b0 = pick_scale();
        it.b1 = pick_scale();
        it.b2 = pick_scale();
        it.b3 = pick_scale();
      end else if (sel < 93) begin
        it = make_request(CMD_LOAD_AFF, 6'($urandom_range(0, 7)), pick_scale(), pick_scale(),
                          pick_scale(), pick_scale(), 1'($urandom_range(0, 1)));
      end else begin
        it = make_request($urandom_range(0, 1) ? 2'd3 : CMD_QUERY, 6'($urandom()),
                          $urandom(), $urandom(), $urandom(), $urandom(),
                          1'($urandom_range(0, 1)));
      end
      pending_requests.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_ch.valid || expected_warps.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_ch.payload <= '{index: index, data: data};
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (index == CFG_ACTIVE_KNOTS) knots_reg = data[6:0];
    else if (index == CFG_ACTIVE_DIMS) dims_reg = data[1:0];
    @(posedge clk);
  endtask

  initial begin
    logic [6:0] knot_set [6];
    logic [1:0] dim_set [6];
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    knots_loaded = 1'b0;
    knots_reg = 7'd64;
    dims_reg = 2'd2;
    fail_count = 0;
    in_taken = 0;
    gap_max = 0;
    stall_max = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pending_requests.push_back(make_request(CMD_QUERY, 6'd0, 32'h7FFFFFFF, 32'h80000000,
                                            32'h0, 32'h00010000, 1'b1));
    pending_requests.push_back(make_request(CMD_LOAD_AFF, 6'd0, 32'h00010000, 0, 0, 0, 1'b0));
    pending_requests.push_back(make_request(CMD_LOAD_AFF, 6'd1, 0, 32'h00010000, 0, 0, 1'b0));
    pending_requests.push_back(make_request(CMD_LOAD_AFF, 6'd2, 0, 0, 32'h00010000, 0, 1'b0));
    pending_requests.push_back(make_request(CMD_LOAD_AFF, 6'd3, 32'h7FFFFFFF, 32'h80000000,
                                            32'h00008000, 32'h00010000, 1'b0));
    pending_requests.push_back(make_request(CMD_LOAD_AFF, 6'd5, $urandom(), $urandom(),
                                            $urandom(), $urandom(), 1'b1));
    pending_requests.push_back(make_request(2'd3, 6'd63, $urandom(), $urandom(),
                                            $urandom(), $urandom(), 1'b1));
    for (int k = 0; k < MAX_KNOTS_DEF; k++)
      pending_requests.push_back(make_request(CMD_LOAD_KNOT, 6'(k),
                                              32'($signed(k * 65536 - 32 * 65536)),
                                              32'($signed(k * 4096)), 32'($signed(-k * 8192)),
                                              0, 1'b0));
    pending_requests[$].a0 = 32'h7FFFFFFF;
    pending_requests[$].a1 = 32'h80000000;
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'($signed(-32 * 65536)), 0, 0,
                                            32'h00010000, 1'b0));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'($signed(-32 * 65536 + 1)), 0, 0,
                                            32'h00010000, 1'b1));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'($signed(-32 * 65536 + 256)), 0,
                                            0, 32'h00010000, 1'b0));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                            32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'h80000000, 32'h80000000,
                                            32'h80000000, 32'h80000000, 1'b0));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                                            32'hFFFFFFFF, 1'b1));
    pending_requests.push_back(make_request(CMD_QUERY, 0, 32'h00000100, 32'h00001000,
                                            32'hFFFF0000, 32'h00010000, 1'b0));
    wait_drained();

    knot_set = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd33};
    dim_set  = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_ACTIVE_KNOTS, {$urandom() & 32'hFFFFFF80} | knot_set[ph]);
        write_reg(CFG_ACTIVE_DIMS, {$urandom() & 32'hFFFFFFFC} | dim_set[ph]);
        if (ph == 3) write_reg(2'd3, $urandom());
      end
      gap_max = (ph % 2 == 0) ? 12 : 0;
      stall_max = (ph % 3 == 1) ? 0 : 12;
      push_random(230);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("thin_plate_spline_evaluator verification clean");
    end else begin
      $display("thin_plate_spline_evaluator verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
